>>> rtl/core/swmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_pkg
// shared constants, types and helpers of the sliding window max filter
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int unsigned DefRadius   = 2;
  localparam int unsigned DefMaxWidth = 1024;

  localparam int unsigned WidthBits  = 11;
  localparam int unsigned HeightBits = 13;
  localparam int unsigned PixelBits  = 8;

  localparam logic [WidthBits-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightBits-1:0] HeightReset = 13'd480;

  // register byte addresses
  localparam logic [2:0] AddrWidth  = 3'd0;
  localparam logic [2:0] AddrHeight = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic clear;  // start a new window max
    logic load;   // read line store at the current tap
    logic wr;     // write the incoming pixel
  } swmf_cmd_t;

endpackage : swmf_pkg
`default_nettype wire

>>> rtl/core/swmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module swmf_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [DataWidth-1:0]     wdata,
  output logic      [DataWidth-1:0]     rdata
);

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : swmf_ram
`default_nettype wire

>>> rtl/core/swmf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_ctrl
// sequencer: position counters, window scan and result beats
// ----------------------------------------------------------------------------
module swmf_ctrl #(
  parameter int unsigned Radius   = swmf_pkg::DefRadius,
  parameter int unsigned MaxWidth = swmf_pkg::DefMaxWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [swmf_pkg::WidthBits-1:0]  frame_width,
  input  wire logic [swmf_pkg::HeightBits-1:0] frame_height,
  input  wire logic                          cfg_wr,
  input  wire logic                          in_valid,
  input  wire logic                          in_drain,
  output logic                               in_stall,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               run_last,
  output logic                               frame_last,
  output swmf_pkg::swmf_cmd_t                cmd,
  output logic [$clog2(2*Radius+1)-1:0]      tap_row,
  output logic [$clog2(MaxWidth)-1:0]        tap_col
);

  localparam int unsigned Rows  = 2 * Radius + 1;
  localparam int unsigned RowW  = $clog2(Rows);
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned CntW  = $clog2(MaxWidth + 1);
  localparam int unsigned HW    = swmf_pkg::HeightBits + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_OUT
  } state_t;

  state_t           state;
  logic [HW-1:0]    row;      // input row
  logic [CntW-1:0]  col;      // input column
  logic             flushing;
  // current result
  logic [HW-1:0]    c_row;
  logic [CntW-1:0]  c_col, c_last;
  // scan position
  logic [HW-1:0]    s_row, s_r1;
  logic [CntW-1:0]  s_col, s_c0, s_c1;
  logic [RowW-1:0]  s_mod;    // s_row mod Rows
  logic             pend;     // scan set up, window loads under way

  logic [CntW-1:0]  w_eff;
  logic [HW-1:0]    h_eff;
  always_comb begin
    w_eff = (frame_width == '0) ? CntW'(1) : CntW'(frame_width);
    if (32'(frame_width) > 32'(MaxWidth)) w_eff = CntW'(MaxWidth);
    h_eff = (frame_height == '0) ? HW'(1) : HW'(frame_height);
  end

  // item-derived values
  logic [HW-1:0]   vrow;
  logic [CntW-1:0  ] first, last;
  logic            any, go;
  always_comb begin
    vrow  = in_drain ? (h_eff + row) : row;
    any   = 1'b1;
    if (col == w_eff - 1'b1) begin
      first = (col >= CntW'(Radius)) ? col - CntW'(Radius) : '0;
      last  = w_eff - 1'b1;
    end else if (col >= CntW'(Radius)) begin
      first = col - CntW'(Radius);
      last  = first;
    end else begin
      first = '0;
      last  = '0;
      any   = 1'b0;
    end
    go = (vrow >= HW'(Radius)) && any && ((vrow - HW'(Radius)) < h_eff);
  end

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  logic [HW-1:0] win_r0, win_r1;
  logic [CntW-1:0] win_c0, win_c1;
  always_comb begin
    win_r0 = (c_row >= HW'(Radius)) ? c_row - HW'(Radius) : '0;
    win_r1 = (c_row + HW'(Radius) > h_eff - 1'b1) ? h_eff - 1'b1 : c_row + HW'(Radius);
    win_c0 = (c_col >= CntW'(Radius)) ? c_col - CntW'(Radius) : '0;
    win_c1 = (c_col + CntW'(Radius) > w_eff - 1'b1) ? w_eff - 1'b1 : c_col + CntW'(Radius);
  end

  logic [RowW-1:0] r0_mod;
  // row index mod Rows by stepping; start from c_row mod kept alongside
  logic [RowW-1:0] c_mod;

  function automatic logic [RowW-1:0] inc_mod(input logic [RowW-1:0] v);
    inc_mod = (v == RowW'(Rows - 1)) ? '0 : v + 1'b1;
  endfunction
  function automatic logic [RowW-1:0] dec_mod(input logic [RowW-1:0] v);
    dec_mod = (v == '0) ? RowW'(Rows - 1) : v - 1'b1;
  endfunction

  logic [RowW-1:0] in_mod; // input row mod Rows
  always_comb begin
    r0_mod = c_mod;
    for (int unsigned k = 0; k < Radius; k++) begin
      if (HW'(k) < c_row) r0_mod = dec_mod(r0_mod);
    end
  end

  logic scan_end;
  assign scan_end = (s_col == s_c1) && (s_row == s_r1);

  always_ff @(posedge clk) begin
    cmd <= '0;
    if (rst || cfg_wr) begin
      state <= S_IDLE; row <= '0; col <= '0; flushing <= 1'b0;
      in_mod <= '0; out_valid <= 1'b0; pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (in_drain == flushing)) begin
            cmd.wr <= !in_drain;
            tap_row <= in_mod;
            tap_col <= ColW'((col >= w_eff) ? '0 : col);
            c_row  <= vrow - HW'(Radius);
            c_col  <= first;
            c_last <= last;
            // center row mod Rows: vrow mod Rows minus Radius
            begin
              logic [RowW-1:0] m;
              m = in_mod;
              for (int unsigned k = 0; k < Radius; k++) m = dec_mod(m);
              c_mod <= m;
            end
            if (go) state <= S_SCAN;
            if (col + 1'b1 >= w_eff) begin
              col <= '0;
              in_mod <= inc_mod(in_mod);
              if (!flushing && row + 1'b1 >= h_eff) begin
                flushing <= 1'b1; row <= '0;
                // drain row continues mod Rows from h_eff
              end else if (flushing && row + 1'b1 >= HW'(Radius)) begin
                flushing <= 1'b0; row <= '0; in_mod <= '0;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
            s_row <= '0;
            pend <= 1'b0;
          end
        end
        S_SCAN: begin
          if (!pend) begin
            s_row <= win_r0; s_r1 <= win_r1;
            s_col <= win_c0; s_c0 <= win_c0; s_c1 <= win_c1;
            s_mod <= r0_mod;
            cmd.clear <= 1'b1;
            pend <= 1'b1;
          end else begin
            tap_row <= s_mod;
            tap_col <= ColW'(s_col);
            cmd.load <= 1'b1;
            if (scan_end) begin
              state <= S_WAIT;
            end else if (s_col == s_c1) begin
              s_col <= s_c0; s_row <= s_row + 1'b1; s_mod <= inc_mod(s_mod);
            end else begin
              s_col <= s_col + 1'b1;
            end
          end
        end
        S_WAIT: begin
          // last read data arrives, folded next cycle
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            run_last   <= (c_col == c_last);
            frame_last <= (c_row == h_eff - 1'b1) && (c_col == w_eff - 1'b1);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            pend <= 1'b0;
            if (c_col == c_last) begin
              state <= S_IDLE;
            end else begin
              c_col <= c_col + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !out_valid) else $error("result beat while idle");
  a_held: assert property (@(posedge clk) disable iff (rst || cfg_wr)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");
`endif

endmodule : swmf_ctrl
`default_nettype wire

>>> rtl/core/swmf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_dp
// line store and running max datapath
// ----------------------------------------------------------------------------
module swmf_dp #(
  parameter int unsigned Radius   = swmf_pkg::DefRadius,
  parameter int unsigned MaxWidth = swmf_pkg::DefMaxWidth
) (
  input  wire logic                              clk,
  input  wire swmf_pkg::swmf_cmd_t               cmd,
  input  wire logic [$clog2(2*Radius+1)-1:0]     tap_row,
  input  wire logic [$clog2(MaxWidth)-1:0]       tap_col,
  input  wire logic [swmf_pkg::PixelBits-1:0]    pixel_value,
  output logic [swmf_pkg::PixelBits-1:0]         max_value
);

  localparam int unsigned Rows  = 2 * Radius + 1;
  localparam int unsigned Depth = Rows * MaxWidth;
  localparam int unsigned AW    = $clog2(Depth);

  logic [swmf_pkg::PixelBits-1:0] pix_q, rdata, best;
  logic [AW-1:0] addr;
  logic load_q;

  always_ff @(posedge clk) begin
    pix_q <= pixel_value;
  end

  assign addr = AW'(tap_row) * AW'(MaxWidth) + AW'(tap_col);

  swmf_ram #(.DataWidth(swmf_pkg::PixelBits), .Depth(Depth)) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .addr  (addr),
    .wdata (pix_q),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    load_q <= cmd.load;
    if (cmd.clear) best <= '0;
    else if (load_q && rdata > best) best <= rdata;
  end

  assign max_value = best;

endmodule : swmf_dp
`default_nettype wire

>>> rtl/core/sliding_window_max_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// results: a result is valid once its item is taken and the scan of its N in-frame window
//   pixels (up to (2*WINDOW_RADIUS+1)^2) is done; further results of a row end follow,
//   each after its own window scan, once the previous one is taken
// throughput: one item per cycle when it gives no result; in_stall holds new items
//   until every result of an item is taken, one line store read per window pixel
// reset: synchronous, counters clear, registers return to 640 x 480
// ----------------------------------------------------------------------------
// sliding_window_max_filter
// square window grayscale max filter over a raster pixel stream
// ----------------------------------------------------------------------------
module sliding_window_max_filter #(
  parameter int unsigned WINDOW_RADIUS = swmf_pkg::DefRadius,
  parameter int unsigned MAX_WIDTH     = swmf_pkg::DefMaxWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  pixel_value,
  input  wire logic        drain,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       max_value,
  output logic             run_last,
  output logic             frame_last
);

  logic [swmf_pkg::WidthBits-1:0]  frame_width;
  logic [swmf_pkg::HeightBits-1:0] frame_height;
  logic cfg_wr;
  swmf_pkg::swmf_cmd_t cmd;
  logic [$clog2(2*WINDOW_RADIUS+1)-1:0] tap_row;
  logic [$clog2(MAX_WIDTH)-1:0] tap_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= swmf_pkg::WidthReset;
      frame_height <= swmf_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (paddr)
        swmf_pkg::AddrWidth:  frame_width  <= pwdata[swmf_pkg::WidthBits-1:0];
        swmf_pkg::AddrHeight: frame_height <= pwdata[swmf_pkg::HeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      swmf_pkg::AddrWidth:  prdata = 32'(frame_width);
      swmf_pkg::AddrHeight: prdata = 32'(frame_height);
      default:              prdata = '0;
    endcase
  end

  swmf_ctrl #(.Radius(WINDOW_RADIUS), .MaxWidth(MAX_WIDTH)) u_ctrl (
    .clk, .rst, .frame_width, .frame_height, .cfg_wr,
    .in_valid, .in_drain(drain), .in_stall, .out_stall, .out_valid,
    .run_last, .frame_last, .cmd, .tap_row, .tap_col
  );

  swmf_dp #(.Radius(WINDOW_RADIUS), .MaxWidth(MAX_WIDTH)) u_dp (
    .clk, .cmd, .tap_row, .tap_col, .pixel_value, .max_value
  );

endmodule : sliding_window_max_filter
`default_nettype wire

>>> tb/sliding_window_max_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_filter_tb
// streams small raster frames and flush beats through the max filter, keeps a
// software dilation model of the line stores and compares every result beat
// ----------------------------------------------------------------------------
module sliding_window_max_filter_tb;

  localparam int Radius   = swmf_pkg::DefRadius;
  localparam int MaxWidth = swmf_pkg::DefMaxWidth;
  localparam int Rows     = 2 * Radius + 1;
  localparam int SettleCycles = 200;

  typedef struct packed {
    logic [7:0] max_value;
    logic       run_last;
    logic       frame_last;
  } dilation_beat_t;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;
  typedef enum int { PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_ONE_BIT } pixel_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] pixel_value = '0;
  logic drain = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] max_value;
  logic run_last;
  logic frame_last;

  sliding_window_max_filter u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .pixel_value, .drain,
    .out_valid, .out_stall, .max_value, .run_last, .frame_last
  );

  // model state
  logic [7:0]                      line_pix [Rows][MaxWidth];
  logic [swmf_pkg::WidthBits-1:0]  width_reg;
  logic [swmf_pkg::HeightBits-1:0] height_reg;
  int unsigned cur_row, cur_col;
  bit          flushing;

  dilation_beat_t expected_beats[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int errors = 0;
  int items_taken = 0;
  int beats_checked = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("sliding_window_max_filter test failed");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [7:0] window_peak(int unsigned cr, int unsigned cc,
                                             int unsigned w, int unsigned h);
    int unsigned r0, r1, c0, c1;
    logic [7:0] best;
    r0 = (cr >= Radius) ? cr - Radius : 0;
    c0 = (cc >= Radius) ? cc - Radius : 0;
    r1 = (cr + Radius > h - 1) ? h - 1 : cr + Radius;
    c1 = (cc + Radius > w - 1) ? w - 1 : cc + Radius;
    best = '0;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        if (line_pix[r % Rows][c] > best) best = line_pix[r % Rows][c];
    return best;
  endfunction

  function automatic void restart_frame();
    cur_row = 0;
    cur_col = 0;
    flushing = 1'b0;
  endfunction

  function automatic void predict_dilation(logic [7:0] pix, bit is_drain);
    int unsigned w, h, vrow, cr, first, last;
    bit any;
    dilation_beat_t b;
    w = eff_width();
    h = eff_height();
    if (is_drain != flushing) return;  // out-of-phase beat is dropped
    items_taken++;
    if (cur_col >= w) cur_col = 0;
    if (!is_drain) begin
      vrow = cur_row;
      line_pix[vrow % Rows][cur_col] = pix;
    end else begin
      vrow = h + cur_row;
    end
    if (vrow >= Radius) begin
      cr = vrow - Radius;
      any = 1'b1;
      if (cur_col == w - 1) begin
        first = (cur_col >= Radius) ? cur_col - Radius : 0;
        last = w - 1;
      end else if (cur_col >= Radius) begin
        first = cur_col - Radius;
        last = first;
      end else begin
        first = 0;
        last = 0;
        any = 1'b0;
      end
      if (any && cr < h)
        for (int unsigned cc = first; cc <= last; cc++) begin
          b.max_value = window_peak(cr, cc, w, h);
          b.run_last = (cc == last);
          b.frame_last = (cr == h - 1 && cc == w - 1);
          expected_beats.push_back(b);
        end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (!flushing && cur_row >= h) begin
        flushing = 1'b1;
        cur_row = 0;
      end else if (flushing && cur_row >= Radius) begin
        restart_frame();
      end
    end
  endfunction

  // accept side first, then compare any result beat
  always @(posedge clk) begin
    dilation_beat_t exp_b;
    if (!rst && in_valid && !in_stall) predict_dilation(pixel_value, drain);
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat max=%0d run_last=%0b frame_last=%0b",
                 $time, max_value, run_last, frame_last);
        errors++;
      end else begin
        exp_b = expected_beats.pop_front();
        beats_checked++;
        if (max_value !== exp_b.max_value) begin
          $display("%0t: max_value expected %0d got %0d", $time, exp_b.max_value, max_value);
          errors++;
        end
        if (run_last !== exp_b.run_last) begin
          $display("%0t: run_last expected %0b got %0b", $time, exp_b.run_last, run_last);
          errors++;
        end
        if (frame_last !== exp_b.frame_last) begin
          $display("%0t: frame_last expected %0b got %0b", $time,
                   exp_b.frame_last, frame_last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 74);
      IDLE_BOTH:     out_stall <= ($urandom_range(99) < 10);
      default:       out_stall <= 1'b0;
    endcase
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 74;
      IDLE_BOTH:   return $urandom_range(99) < 10;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic send_beat(logic [7:0] pix, bit is_drain);
    @(negedge clk);
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= pix;
    drain <= is_drain;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == swmf_pkg::AddrWidth) width_reg = data[swmf_pkg::WidthBits-1:0];
    else height_reg = data[swmf_pkg::HeightBits-1:0];
    restart_frame();
  endtask

  task automatic reg_check(logic [2:0] addr, logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d expected %0d got %0d", $time, addr, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    reg_write(swmf_pkg::AddrWidth, w);
    reg_write(swmf_pkg::AddrHeight, h);
  endtask

  function automatic logic [7:0] pick_pixel(pixel_pattern_t pat);
    case (pat)
      PAT_ZERO:    return 8'h00;
      PAT_FULL:    return 8'hff;
      PAT_ONE_BIT: return 8'h01 << $urandom_range(7);
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  // a whole frame plus flush; noise_pct injects out-of-phase beats,
  // cut_at stops the frame early (-1 = never)
  task automatic send_frame(pixel_pattern_t pat, int noise_pct, int cut_at = -1);
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    n = 0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if (n == cut_at) return;
      if ($urandom_range(99) < noise_pct) send_beat(8'($urandom_range(255)), 1'b1);
      send_beat(pick_pixel(pat), 1'b0);
      n++;
    end
    for (int unsigned i = 0; i < Radius * w; i++) begin
      if ($urandom_range(99) < noise_pct) send_beat(8'($urandom_range(255)), 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic test_registers();
    reg_check(swmf_pkg::AddrWidth, swmf_pkg::WidthReset);
    reg_check(swmf_pkg::AddrHeight, swmf_pkg::HeightReset);
    set_size(11'h7ff, 13'h1fff);
    reg_check(swmf_pkg::AddrWidth, 11'h7ff);
    reg_check(swmf_pkg::AddrHeight, 13'h1fff);
    set_size(5, 4);
    reg_check(swmf_pkg::AddrWidth, 5);
    reg_check(swmf_pkg::AddrHeight, 4);
  endtask

  task automatic test_directed();
    // single pixel frame
    set_size(1, 1);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b1);
    wait_idle();
    // zero sizes behave as one
    set_size(0, 0);
    send_beat(8'h00, 1'b1);  // flush beat while a pixel is due
    send_beat(8'h5a, 1'b0);
    send_beat(8'h11, 1'b0);  // pixel while flushing
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b1);
    wait_idle();
    // 3x2 with extremes: ff in the top row middle, 80 and 7f in the bottom corners
    set_size(3, 2);
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7f, 1'b0);
    for (int i = 0; i < 6; i++) send_beat(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_large_frames();
    // wide flat frame with many column positions, then a tall narrow one
    set_size(24, 2);
    send_frame(PAT_RANDOM, 0);
    wait_idle();
    set_size(2, 20);
    send_frame(PAT_RANDOM, 0);
    wait_idle();
  endtask

  task automatic test_random_frames(idle_mode_t mode, int item_budget);
    int start;
    pixel_pattern_t pat;
    idle_mode = mode;
    start = items_taken;
    while (items_taken - start < item_budget) begin
      set_size($urandom_range(1, 8), $urandom_range(1, 6));
      pat = pixel_pattern_t'(($urandom_range(9) < 7) ? PAT_RANDOM : $urandom_range(3));
      if ($urandom_range(9) == 0) send_frame(pat, 10, $urandom_range(1, 10));
      else send_frame(pat, ($urandom_range(3) == 0) ? 15 : 0);
      wait_idle();
    end
    idle_mode = IDLE_NONE;
  endtask

  initial begin
    width_reg = swmf_pkg::WidthReset;
    height_reg = swmf_pkg::HeightReset;
    restart_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_registers();
    test_directed();
    test_large_frames();
    test_random_frames(IDLE_NONE, 40);
    test_random_frames(IDLE_SENDER, 40);
    test_random_frames(IDLE_RECEIVER, 40);
    test_random_frames(IDLE_BOTH, 40);
    wait_idle();
    $display("covered %0d accepted pixel/flush beats and %0d checked results", items_taken,
             beats_checked);
    $display("sizes from 1x1 to 24 wide and 20 tall, four idle/stall mixes");
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("sliding_window_max_filter test passed");
    end else begin
      $display("sliding_window_max_filter test failed");
    end
    $finish;
  end

endmodule

>>> sliding_window_max_filter.f
rtl/core/swmf_pkg.sv
rtl/core/swmf_ram.sv
rtl/core/swmf_ctrl.sv
rtl/core/swmf_dp.sv
rtl/core/sliding_window_max_filter.sv
tb/sliding_window_max_filter_tb.sv
